>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on clk, masked during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication on clk, masked during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, masked during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/qrd_pkg.sv
// Shared types and constants for the quad region detector.
package qrd_pkg;

  localparam int NUM_CORNER_REGS = 8;
  localparam int REG_IDX_BITS    = 3;
  localparam int PIX_VAL_BITS    = 8;
  localparam int OUT_TDATA_BITS  = 8;

  localparam logic [PIX_VAL_BITS-1:0] SET_PIXEL = 8'hFF;
  // doubled-area tolerance (real area under 5)
  localparam int DOUBLED_TOL = 10;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_TL_X = 3'd0,
    REG_TL_Y = 3'd1,
    REG_TR_X = 3'd2,
    REG_TR_Y = 3'd3,
    REG_BL_X = 3'd4,
    REG_BL_Y = 3'd5,
    REG_BR_X = 3'd6,
    REG_BR_Y = 3'd7
  } cfg_reg_t;

  // status of the item leaving the area pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } pipe_status_t;

endpackage

>>> rtl/core/qrd_cfg_regs.sv
// Corner coordinate register file written through the config channel.
module qrd_cfg_regs
  import qrd_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  output logic [COORD_BITS-1:0]   corners [NUM_CORNER_REGS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CORNER_REGS; i++) begin
        corners[i] <= '0;
      end
    end else if (cfg_valid) begin
      corners[cfg_index] <= cfg_data;
    end
  end

endmodule

>>> rtl/core/qrd_area_pipe.sv
// Area test pipeline: input register, product register, magnitude register.
module qrd_area_pipe
  import qrd_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [COORD_BITS-1:0]   pix_x,
  input  logic [COORD_BITS-1:0]   pix_y,
  input  logic [PIX_VAL_BITS-1:0] pix_val,
  input  logic                    frame_end,
  input  logic [COORD_BITS-1:0]   corners [NUM_CORNER_REGS],
  output pipe_status_t            status
);

  localparam int DW = COORD_BITS + 1;   // signed coordinate difference
  localparam int PW = 2 * DW;           // signed product
  localparam int CW = PW + 1;           // signed cross product
  localparam int SW = PW + 2;           // sum of four magnitudes
  localparam int QW = PW + 1;           // sum of two magnitudes
  localparam int FW = PW + 3;           // signed area difference
  localparam int NTRI = 6;              // four part triangles, two quad halves

  // stage 1: input register
  logic                  s1_valid;
  logic                  s1_last;
  logic                  s1_set;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;

  // stage 2: products
  logic                  s2_valid;
  logic                  s2_last;
  logic                  s2_set;
  logic signed [PW-1:0]  s2_pa [NTRI];
  logic signed [PW-1:0]  s2_pb [NTRI];

  // stage 3: magnitudes
  logic                  s3_valid;
  logic                  s3_last;
  logic                  s3_set;
  logic [PW-1:0]         s3_mag [NTRI];

  // triangle apex and edge ends
  logic [COORD_BITS-1:0] ax [NTRI];
  logic [COORD_BITS-1:0] ay [NTRI];
  logic [COORD_BITS-1:0] bx [NTRI];
  logic [COORD_BITS-1:0] by [NTRI];
  logic [COORD_BITS-1:0] cx [NTRI];
  logic [COORD_BITS-1:0] cy [NTRI];

  logic signed [DW-1:0]  ux [NTRI];
  logic signed [DW-1:0]  uy [NTRI];
  logic signed [DW-1:0]  vx [NTRI];
  logic signed [DW-1:0]  vy [NTRI];
  logic signed [CW-1:0]  xprod [NTRI];
  logic [PW-1:0]         mag [NTRI];

  logic [SW-1:0]         parts_sum;
  logic [QW-1:0]         quad_sum;
  logic signed [FW-1:0]  area_diff;
  logic [FW-1:0]         area_absdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last <= frame_end;
      s1_set  <= (pix_val == SET_PIXEL);
      s1_x    <= pix_x;
      s1_y    <= pix_y;
      s2_last <= s1_last;
      s2_set  <= s1_set;
      for (int t = 0; t < NTRI; t++) begin
        s2_pa[t] <= PW'(ux[t] * vy[t]);
        s2_pb[t] <= PW'(uy[t] * vx[t]);
      end
      s3_last <= s2_last;
      s3_set  <= s2_set;
      s3_mag  <= mag;
    end
  end

  // Part triangles join the pixel to each quad edge; the quad itself is
  // split into (tl,bl,tr) and (tr,br,bl).
  always_comb begin
    ax[0] = s1_x;                 ay[0] = s1_y;
    bx[0] = corners[REG_TL_X];    by[0] = corners[REG_TL_Y];
    cx[0] = corners[REG_TR_X];    cy[0] = corners[REG_TR_Y];
    ax[1] = s1_x;                 ay[1] = s1_y;
    bx[1] = corners[REG_TR_X];    by[1] = corners[REG_TR_Y];
    cx[1] = corners[REG_BR_X];    cy[1] = corners[REG_BR_Y];
    ax[2] = s1_x;                 ay[2] = s1_y;
    bx[2] = corners[REG_BR_X];    by[2] = corners[REG_BR_Y];
    cx[2] = corners[REG_BL_X];    cy[2] = corners[REG_BL_Y];
    ax[3] = s1_x;                 ay[3] = s1_y;
    bx[3] = corners[REG_BL_X];    by[3] = corners[REG_BL_Y];
    cx[3] = corners[REG_TL_X];    cy[3] = corners[REG_TL_Y];
    ax[4] = corners[REG_TL_X];    ay[4] = corners[REG_TL_Y];
    bx[4] = corners[REG_BL_X];    by[4] = corners[REG_BL_Y];
    cx[4] = corners[REG_TR_X];    cy[4] = corners[REG_TR_Y];
    ax[5] = corners[REG_TR_X];    ay[5] = corners[REG_TR_Y];
    bx[5] = corners[REG_BR_X];    by[5] = corners[REG_BR_Y];
    cx[5] = corners[REG_BL_X];    cy[5] = corners[REG_BL_Y];
  end

  always_comb begin
    for (int t = 0; t < NTRI; t++) begin
      ux[t] = signed'({1'b0, bx[t]}) - signed'({1'b0, ax[t]});
      uy[t] = signed'({1'b0, by[t]}) - signed'({1'b0, ay[t]});
      vx[t] = signed'({1'b0, cx[t]}) - signed'({1'b0, ax[t]});
      vy[t] = signed'({1'b0, cy[t]}) - signed'({1'b0, ay[t]});
      xprod[t] = CW'(s2_pa[t]) - CW'(s2_pb[t]);
      // magnitude never exceeds 2^(2*COORD_BITS+1), fits PW bits
      mag[t] = xprod[t][CW-1] ? PW'(-xprod[t]) : PW'(xprod[t]);
    end
  end

  always_comb begin
    parts_sum = SW'(s3_mag[0]) + SW'(s3_mag[1]) + SW'(s3_mag[2]) + SW'(s3_mag[3]);
    quad_sum  = QW'(s3_mag[4]) + QW'(s3_mag[5]);
    area_diff = signed'(FW'(quad_sum)) - signed'(FW'(parts_sum));
    area_absdiff = area_diff[FW-1] ? FW'(-area_diff) : FW'(area_diff);
  end

  assign status.valid = s3_valid;
  assign status.last  = s3_last;
  assign status.hit   = s3_set && (area_absdiff < FW'(DOUBLED_TOL));

endmodule

>>> rtl/core/qrd_out_stage.sv
// Sticky hit flag and frame result register.
module qrd_out_stage
  import qrd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  pipe_status_t status,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         out_hit
);

  logic hit_seen;
  logic frame_done;

  assign frame_done = en && status.valid && status.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= frame_done || (out_valid && !out_ready);
      if (en && status.valid) begin
        if (status.last) begin
          hit_seen <= 1'b0;
        end else begin
          hit_seen <= hit_seen | status.hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      out_hit <= hit_seen | status.hit;
    end
  end

endmodule

>>> rtl/core/pixel_in_quad_region_detect.sv
// Top level of the pixel in quadrilateral region detector.
//
// Pixels enter on the s_ stream: s_tdata holds pix_x, pix_y and pix_val,
// s_tlast marks the last pixel of a frame. Every pixel equal to 255 is tested
// against the quad held in the corner registers (doubled-area test, tolerance DOUBLED_TOL).
// One transaction leaves on the m_ stream per frame, at its last pixel:
// m_tdata[0] is 1 if any set pixel of that frame lay inside the quad.
// Corners are written on the cfg_ channel (index 0..7, always ready) and
// must only change while no pixel is in flight.
// Throughput: one pixel per clock while no result waits on a low m_tready.
// The frame result reaches m_tvalid through the input, product and magnitude
// registers, then the result register.
// The whole pipeline moves together; it holds while a result waits on a low
// m_tready, so s_tready follows m_tready whenever a result is pending.
// Reset clears the corners to zero, the sticky hit flag and all valid bits.
module pixel_in_quad_region_detect
  import qrd_pkg::*;
#(
  parameter int COORD_BITS = 10,
  localparam int IN_W = ((2 * COORD_BITS + PIX_VAL_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_W-1:0]           s_tdata,   // pix_x, pix_y, pix_val, zero pad
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,   // region_hit, zero pad
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [REG_IDX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data
);

  logic                  en;
  logic                  out_hit;
  logic [COORD_BITS-1:0] corners [NUM_CORNER_REGS];
  pipe_status_t          status;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(OUT_TDATA_BITS-1){1'b0}}, out_hit};

  qrd_cfg_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .corners  (corners)
  );

  qrd_area_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .pix_x      (s_tdata[COORD_BITS-1:0]),
    .pix_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pix_val    (s_tdata[2*COORD_BITS+PIX_VAL_BITS-1:2*COORD_BITS]),
    .frame_end  (s_tlast),
    .corners    (corners),
    .status     (status)
  );

  qrd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .status   (status),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_hit  (out_hit)
  );

endmodule

>>> rtl/core/qrd_checker.sv
// Port-level checks for the quad region detector, bound to the top level.
`include "assert_macros.svh"

module qrd_checker
  import qrd_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata
);

  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
  `ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_BITS-1:1] == '0, "nonzero result padding")
  `ASSERT_IMPL(a_ready_follow, m_tready || !m_tvalid, s_tready, "input blocked with output free")
  `ASSERT_CLK(a_reset_empty, !$past(rst) || !m_tvalid, "result valid right after reset")

endmodule

bind pixel_in_quad_region_detect qrd_checker u_qrd_checker (.*);

>>> tb/pixel_in_quad_region_detect_tb.sv
// Testbench for the pixel in quadrilateral region detector.
module pixel_in_quad_region_detect_tb;
  import qrd_pkg::*;

  localparam int COORD_BITS  = 10;
  localparam int IN_W        = ((2 * COORD_BITS + PIX_VAL_BITS + 7) / 8) * 8;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int SET_VAL     = int'(SET_PIXEL);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 450;
  localparam int RAND_PHASES = 10;

  // Tracks the corners and the sticky hit flag, and holds the frame results
  // still owed by the block.
  class quad_hit_tracker;
    logic [COORD_BITS-1:0] corner_reg [NUM_CORNER_REGS];
    bit hit_seen;
    bit expected_hits [$];
    int errors;

    function new();
      foreach (corner_reg[i]) corner_reg[i] = '0;
      hit_seen = 1'b0;
      errors   = 0;
    endfunction

    function void set_corner(cfg_reg_t idx, logic [COORD_BITS-1:0] val);
      corner_reg[idx] = val;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    // doubled triangle area: magnitude of the cross product
    function longint twice_tri(longint ax, longint ay, longint bx, longint by,
                               longint cx, longint cy);
      longint d;
      d = (ax * by + bx * cy + cx * ay) - (ay * bx + by * cx + cy * ax);
      return (d < 0) ? -d : d;
    endfunction

    function bit pixel_in_quad(longint px, longint py);
      longint tlx, tly, trx, tr_y, blx, bly, brx, bry;
      longint quad_area, part_sum, diff;
      tlx  = longint'(corner_reg[REG_TL_X]);
      tly  = longint'(corner_reg[REG_TL_Y]);
      trx  = longint'(corner_reg[REG_TR_X]);
      tr_y = longint'(corner_reg[REG_TR_Y]);
      blx  = longint'(corner_reg[REG_BL_X]);
      bly  = longint'(corner_reg[REG_BL_Y]);
      brx  = longint'(corner_reg[REG_BR_X]);
      bry  = longint'(corner_reg[REG_BR_Y]);
      quad_area = twice_tri(tlx, tly, blx, bly, trx, tr_y)
                + twice_tri(trx, tr_y, brx, bry, blx, bly);
      part_sum  = twice_tri(px, py, tlx, tly, trx, tr_y)
                + twice_tri(px, py, trx, tr_y, brx, bry)
                + twice_tri(px, py, brx, bry, blx, bly)
                + twice_tri(px, py, blx, bly, tlx, tly);
      diff = quad_area - part_sum;
      if (diff < 0) diff = -diff;
      return diff < DOUBLED_TOL;
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                             logic [PIX_VAL_BITS-1:0] val, logic last);
      if (val == SET_PIXEL && pixel_in_quad(longint'(x), longint'(y))) hit_seen = 1'b1;
      if (last) begin
        expected_hits.push_back(hit_seen);
        hit_seen = 1'b0;
      end
    endfunction

    function void check_hit(logic hit);
      bit want;
      if (expected_hits.size() == 0) begin
        $error("region_hit: expected none, actual %0b", hit);
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      if (hit !== want) begin
        $error("region_hit: expected %0b, actual %0b", want, hit);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_W-1:0]           s_tdata = '0;  // pix_x, pix_y, pix_val, zero pad
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;       // region_hit, zero pad
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [REG_IDX_BITS-1:0]   cfg_index = REG_TL_X;
  logic [COORD_BITS-1:0]     cfg_data = '0;

  quad_hit_tracker sb = new();

  logic [COORD_BITS-1:0] quad_now [NUM_CORNER_REGS];
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_taken   = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  int counted      = 0;

  pixel_in_quad_region_detect #(.COORD_BITS(COORD_BITS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Both streams are observed here; results are checked before the new pixel
  // is noted, though a result never depends on a pixel of the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_hit(m_tdata[0]);
      if (s_tvalid && s_tready)
        sb.note_pixel(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS],
                      s_tdata[2*COORD_BITS +: PIX_VAL_BITS], s_tlast);
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_req) begin
      m_tready   <= 1'b0;
      hold_taken <= hold_req;
      hold_left  <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input int x, input int y, input int val, input bit last);
    logic [IN_W-1:0] word;
    word = '0;
    word[COORD_BITS-1:0]               = COORD_BITS'(x);
    word[2*COORD_BITS-1:COORD_BITS]    = COORD_BITS'(y);
    word[2*COORD_BITS +: PIX_VAL_BITS] = PIX_VAL_BITS'(val);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_corners();
    cfg_reg_t r;
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= quad_now[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_corner(r, quad_now[r]);
      @(negedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
  endtask

  task automatic set_corners(input int tlx, input int tly, input int trx, input int tr_y,
                             input int blx, input int bly, input int brx, input int bry);
    quad_now[REG_TL_X] = COORD_BITS'(tlx);
    quad_now[REG_TL_Y] = COORD_BITS'(tly);
    quad_now[REG_TR_X] = COORD_BITS'(trx);
    quad_now[REG_TR_Y] = COORD_BITS'(tr_y);
    quad_now[REG_BL_X] = COORD_BITS'(blx);
    quad_now[REG_BL_Y] = COORD_BITS'(bly);
    quad_now[REG_BR_X] = COORD_BITS'(brx);
    quad_now[REG_BR_Y] = COORD_BITS'(bry);
    write_corners();
  endtask

  // Lower valid, wait for every owed frame result, then let the pipe empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_quad(input int kind);
    int x0, x1, y0, y1, c;
    case (kind)
      0: begin
        x0 = $urandom_range(COORD_MAX);
        x1 = $urandom_range(COORD_MAX, x0);
        y0 = $urandom_range(COORD_MAX);
        y1 = $urandom_range(COORD_MAX, y0);
        set_corners(x0, y0, x1, y0, x0, y1, x1, y1);
      end
      1: set_corners($urandom_range(511), $urandom_range(511),
                     $urandom_range(COORD_MAX, 512), $urandom_range(511),
                     $urandom_range(511), $urandom_range(COORD_MAX, 512),
                     $urandom_range(COORD_MAX, 512), $urandom_range(COORD_MAX, 512));
      // lower corners swapped: self-crossing outline
      2: set_corners($urandom_range(511), $urandom_range(511),
                     $urandom_range(COORD_MAX, 512), $urandom_range(511),
                     $urandom_range(COORD_MAX, 512), $urandom_range(COORD_MAX, 512),
                     $urandom_range(511), $urandom_range(COORD_MAX, 512));
      3: set_corners($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      default: begin
        // zero area: all corners on one row
        c = $urandom_range(COORD_MAX);
        set_corners($urandom_range(COORD_MAX), c, $urandom_range(COORD_MAX), c,
                    $urandom_range(COORD_MAX), c, $urandom_range(COORD_MAX), c);
      end
    endcase
  endtask

  task automatic pick_pixel(output int x, output int y);
    int xs [4];
    int ys [4];
    int xmin, xmax, ymin, ymax, k;
    xs[0] = int'(quad_now[REG_TL_X]); ys[0] = int'(quad_now[REG_TL_Y]);
    xs[1] = int'(quad_now[REG_TR_X]); ys[1] = int'(quad_now[REG_TR_Y]);
    xs[2] = int'(quad_now[REG_BL_X]); ys[2] = int'(quad_now[REG_BL_Y]);
    xs[3] = int'(quad_now[REG_BR_X]); ys[3] = int'(quad_now[REG_BR_Y]);
    xmin = xs[0]; xmax = xs[0]; ymin = ys[0]; ymax = ys[0];
    for (int i = 1; i < 4; i++) begin
      if (xs[i] < xmin) xmin = xs[i];
      if (xs[i] > xmax) xmax = xs[i];
      if (ys[i] < ymin) ymin = ys[i];
      if (ys[i] > ymax) ymax = ys[i];
    end
    case ($urandom_range(3))
      0: begin
        x = $urandom_range(COORD_MAX);
        y = $urandom_range(COORD_MAX);
      end
      1, 2: begin
        x = $urandom_range(xmax, xmin);
        y = $urandom_range(ymax, ymin);
      end
      default: begin
        // close to a corner, where the tolerance matters
        k = $urandom_range(3);
        x = xs[k] + $urandom_range(6) - 3;
        y = ys[k] + $urandom_range(6) - 3;
        if (x < 0) x = 0;
        if (x > COORD_MAX) x = COORD_MAX;
        if (y < 0) y = 0;
        if (y > COORD_MAX) y = COORD_MAX;
      end
    endcase
  endtask

  task automatic random_frame();
    int len, x, y, val;
    bit last;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(5, 1);
    for (int i = 0; i < len; i++) begin
      pick_pixel(x, y);
      val  = ($urandom_range(99) < 60) ? SET_VAL : $urandom_range(255);
      last = (i == len - 1);
      send_pixel(x, y, val, last);
      counted++;
    end
  endtask

  initial begin
    int phase_goal;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset corners are all at the origin: any set pixel hits
    send_pixel(0, 0, SET_VAL, 1'b1);
    send_pixel(COORD_MAX, 512, SET_VAL, 1'b1);
    drain();

    set_corners(100, 100, 300, 100, 100, 300, 300, 300);
    send_pixel(200, 200, SET_VAL, 1'b1);
    send_pixel(200, 200, 254, 1'b1);
    send_pixel(0, 0, SET_VAL, 1'b1);
    send_pixel(COORD_MAX, COORD_MAX, SET_VAL, 1'b1);
    // a hit early in the frame must stick to its end
    send_pixel(200, 200, SET_VAL, 1'b0);
    send_pixel(0, 0, 0, 1'b0);
    send_pixel(COORD_MAX, COORD_MAX, SET_VAL, 1'b1);
    // hit on the last pixel itself
    send_pixel(5, 5, SET_VAL, 1'b0);
    send_pixel(100, 100, SET_VAL, 1'b1);
    send_pixel(300, 300, 0, 1'b1);
    send_pixel(300, 301, SET_VAL, 1'b1);
    send_pixel(0, COORD_MAX, 128, 1'b1);
    drain();

    set_corners(0, 0, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX);
    send_pixel(COORD_MAX, COORD_MAX, SET_VAL, 1'b1);
    send_pixel(512, 0, SET_VAL, 1'b1);
    send_pixel(0, COORD_MAX, 127, 1'b1);
    drain();

    set_corners(0, 500, COORD_MAX, 500, 0, 500, COORD_MAX, 500);
    send_pixel(600, 500, SET_VAL, 1'b1);
    send_pixel(600, 501, SET_VAL, 1'b1);
    drain();

    set_corners(100, 100, 300, 100, 300, 300, 100, 300);
    send_pixel(200, 200, SET_VAL, 1'b1);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      random_quad(p % 5);
      phase_goal = counted + RAND_ITEMS / RAND_PHASES;
      while (counted < phase_goal) begin
        random_frame();
        if (p == 4 && hold_req == 0) hold_req++;
        if (p == 6 && counted >= phase_goal - 20 && counted < phase_goal - 10) begin
          s_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/qrd_pkg.sv
rtl/core/qrd_cfg_regs.sv
rtl/core/qrd_area_pipe.sv
rtl/core/qrd_out_stage.sv
rtl/core/pixel_in_quad_region_detect.sv
rtl/core/qrd_checker.sv
tb/pixel_in_quad_region_detect_tb.sv
